### hdl/ssui_pkg.sv
// Shared types and constants for the sorted set union/intersection block.
// Holds the item and result structs, the command codes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package ssui_pkg;

    // Element width and default store depth
    localparam int ELEM_W            = 32;
    localparam int SSUI_STORE_DEPTH  = 16;

    // Most results a single stream returns, and the width of its counter
    localparam int RESULT_CAP = 32;
    localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

    // Command codes
    localparam logic [1:0] CMD_INS_A = 2'd0;
    localparam logic [1:0] CMD_INS_B = 2'd1;
    localparam logic [1:0] CMD_UNION = 2'd2;
    localparam logic [1:0] CMD_ISECT = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [ELEM_W-1:0] value;
    } req_t;

    // Result item
    typedef struct packed {
        logic signed [ELEM_W-1:0] item;
        logic                     item_present;
        logic                     last;
        logic                     store_full;
    } result_t;

    // Control broadcast to every cell of one store
    typedef struct packed {
        logic                     ins;
        logic                     rot;
        logic signed [ELEM_W-1:0] val;
    } store_ctl_t;

endpackage

### hdl/ssui_cell.sv
// One cell of a sorted store: holds one element and trades it with its neighbors.
// Supports an ordered insert (shift right past the insert point) and a rotate toward the head.
// Depends on ssui_pkg.
`timescale 1ns / 1ps

module ssui_cell (
    input  logic                               clk,
    input  ssui_pkg::store_ctl_t               ctl,
    input  logic                               valid,
    input  logic                               is_last,
    input  logic                               left_g,
    input  logic signed [ssui_pkg::ELEM_W-1:0] left_val,
    input  logic signed [ssui_pkg::ELEM_W-1:0] right_val,
    input  logic signed [ssui_pkg::ELEM_W-1:0] head_val,
    output logic signed [ssui_pkg::ELEM_W-1:0] val,
    output logic                               g
);
    import ssui_pkg::*;

    logic signed [ELEM_W-1:0] val_reg;
    logic signed [ELEM_W-1:0] val_next;

    // Flag that the new value sorts strictly before this element
    assign g   = valid && (ctl.val < val_reg);
    assign val = val_reg;

    // Pick the next element: shift in from the left, take the new value, or rotate
    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins)
        begin
            if (left_g)
                val_next = left_val;
            else if (g || !valid)
                val_next = ctl.val;
        end
        else if (ctl.rot && valid)
        begin
            val_next = is_last ? head_val : right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### hdl/ssui_store.sv
// A sorted store built as a row of ssui_cell, head at cell 0.
// The valid prefix is set by the count held outside; the head element is read at cell 0.
// Depends on ssui_pkg and ssui_cell.
`timescale 1ns / 1ps

module ssui_store #(
    parameter int DEPTH = ssui_pkg::SSUI_STORE_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  ssui_pkg::store_ctl_t               ctl,
    input  logic [CNT_W-1:0]                   count,
    output logic signed [ssui_pkg::ELEM_W-1:0] head
);
    import ssui_pkg::*;

    logic signed [ELEM_W-1:0] vals [DEPTH];
    logic                     gs   [DEPTH];

    assign head = vals[0];

    // Chain the cells, each seeing its two neighbors and the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     left_g;
        logic signed [ELEM_W-1:0] left_val;
        logic signed [ELEM_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_g   = 1'b0;
            assign left_val = '0;
        end
        else
        begin : g_inner
            assign left_g   = gs[i-1];
            assign left_val = vals[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_mid
            assign right_val = vals[i+1];
        end

        ssui_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .valid     (count > CNT_W'(i)),
            .is_last   (count == CNT_W'(i + 1)),
            .left_g    (left_g),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (vals[0]),
            .val       (vals[i]),
            .g         (gs[i])
        );
    end

endmodule

### hdl/sorted_set_union_intersection.sv
// Top level of the sorted set union/intersection block.
// Holds the command sequencer, two ssui_store rows and the result register.
// Depends on ssui_pkg and ssui_store.
`timescale 1ns / 1ps

// Two ascending stores, A and B, each a row of cells holding up to STORE_DEPTH
// signed values, duplicates kept. An insert leaves busy low, and the status
// result appears on the cycle after start. A union or intersection walks both
// stores from the head, popping one or both head elements per cycle by rotating
// the cell rows and holding busy while it runs; the walk always runs to the end
// so both stores come back in their original order. Results appear one per
// result_valid pulse and must be taken in that cycle; the last one carries last,
// and an empty stream gives one result with item_present low.
module sorted_set_union_intersection #(
    parameter int STORE_DEPTH = ssui_pkg::SSUI_STORE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssui_pkg::req_t    req,
    output logic              result_valid,
    output ssui_pkg::result_t result
);
    import ssui_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]               state_reg,   state_next;
    logic [CNT_W-1:0]         count_a_reg, count_a_next;
    logic [CNT_W-1:0]         count_b_reg, count_b_next;
    logic [CNT_W-1:0]         rem_a_reg,   rem_a_next;
    logic [CNT_W-1:0]         rem_b_reg,   rem_b_next;
    logic [RES_CNT_W-1:0]     k_reg,       k_next;
    logic                     capped_reg,  capped_next;
    logic                     isect_reg,   isect_next;
    logic signed [ELEM_W-1:0] pend_reg,    pend_next;
    logic                     result_valid_reg, result_valid_next;
    result_t                  result_reg,  result_next;

    store_ctl_t               ctl_a, ctl_b;
    logic signed [ELEM_W-1:0] head_a, head_b;
    logic                     accept;
    logic                     full_a, full_b;
    logic                     a_has, b_has;
    logic                     pop_a, pop_b;
    logic                     found;
    logic signed [ELEM_W-1:0] cand;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign full_a = (count_a_reg == CNT_W'(STORE_DEPTH));
    assign full_b = (count_b_reg == CNT_W'(STORE_DEPTH));
    assign a_has  = (rem_a_reg != '0);
    assign b_has  = (rem_b_reg != '0);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    ssui_store #(
        .DEPTH (STORE_DEPTH),
        .CNT_W (CNT_W)
    ) u_store_a (
        .clk   (clk),
        .ctl   (ctl_a),
        .count (count_a_reg),
        .head  (head_a)
    );

    ssui_store #(
        .DEPTH (STORE_DEPTH),
        .CNT_W (CNT_W)
    ) u_store_b (
        .clk   (clk),
        .ctl   (ctl_b),
        .count (count_b_reg),
        .head  (head_b)
    );

    // Choose which heads to pop and whether a new distinct value turns up
    always_comb
    begin
        pop_a = 1'b0;
        pop_b = 1'b0;
        found = 1'b0;
        cand  = head_a;
        if (isect_reg)
        begin
            if (a_has && b_has)
            begin
                pop_a = !(head_b < head_a);
                pop_b = !(head_a < head_b);
                found = pop_a && pop_b;
            end
            else
            begin
                pop_a = a_has;
                pop_b = b_has;
            end
        end
        else if (a_has || b_has)
        begin
            pop_a = !b_has || (a_has && !(head_b < head_a));
            pop_b = !pop_a;
            cand  = pop_a ? head_a : head_b;
            found = 1'b1;
        end
        if (found && k_reg != '0 && cand == pend_reg)
            found = 1'b0;
    end

    // Sequence commands, drive the stores and build results
    always_comb
    begin
        state_next        = state_reg;
        count_a_next      = count_a_reg;
        count_b_next      = count_b_reg;
        rem_a_next        = rem_a_reg;
        rem_b_next        = rem_b_reg;
        k_next            = k_reg;
        capped_next       = capped_reg;
        isect_next        = isect_reg;
        pend_next         = pend_reg;
        result_valid_next = 1'b0;
        result_next       = '{item: '0, item_present: 1'b0, last: 1'b1, store_full: 1'b0};
        ctl_a             = '{ins: 1'b0, rot: 1'b0, val: req.value};
        ctl_b             = '{ins: 1'b0, rot: 1'b0, val: req.value};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.cmd)
                        CMD_INS_A:
                        begin
                            result_valid_next      = 1'b1;
                            result_next.store_full = full_a;
                            if (!full_a)
                            begin
                                ctl_a.ins    = 1'b1;
                                count_a_next = count_a_reg + CNT_W'(1);
                            end
                        end
                        CMD_INS_B:
                        begin
                            result_valid_next      = 1'b1;
                            result_next.store_full = full_b;
                            if (!full_b)
                            begin
                                ctl_b.ins    = 1'b1;
                                count_b_next = count_b_reg + CNT_W'(1);
                            end
                        end
                        CMD_UNION, CMD_ISECT:
                        begin
                            rem_a_next  = count_a_reg;
                            rem_b_next  = count_b_reg;
                            k_next      = '0;
                            capped_next = 1'b0;
                            isect_next  = (req.cmd == CMD_ISECT);
                            state_next  = ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!a_has && !b_has)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ctl_a.rot = pop_a;
                    ctl_b.rot = pop_b;
                    if (pop_a)
                        rem_a_next = rem_a_reg - CNT_W'(1);
                    if (pop_b)
                        rem_b_next = rem_b_reg - CNT_W'(1);
                    // Hold one value back so the final one can carry last
                    if (found && !capped_reg)
                    begin
                        if (k_reg == '0)
                        begin
                            pend_next = cand;
                            k_next    = RES_CNT_W'(1);
                        end
                        else if (k_reg != RES_CNT_W'(RESULT_CAP))
                        begin
                            result_valid_next        = 1'b1;
                            result_next.item         = pend_reg;
                            result_next.item_present = 1'b1;
                            result_next.last         = 1'b0;
                            pend_next                = cand;
                            k_next                   = k_reg + RES_CNT_W'(1);
                        end
                        else
                        begin
                            result_valid_next        = 1'b1;
                            result_next.item         = pend_reg;
                            result_next.item_present = 1'b1;
                            capped_next              = 1'b1;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                if (!capped_reg)
                begin
                    result_valid_next = 1'b1;
                    if (k_reg != '0)
                    begin
                        result_next.item         = pend_reg;
                        result_next.item_present = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_a_reg      <= '0;
            count_b_reg      <= '0;
            rem_a_reg        <= '0;
            rem_b_reg        <= '0;
            k_reg            <= '0;
            capped_reg       <= 1'b0;
            isect_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_a_reg      <= count_a_next;
            count_b_reg      <= count_b_next;
            rem_a_reg        <= rem_a_next;
            rem_b_reg        <= rem_b_next;
            k_reg            <= k_next;
            capped_reg       <= capped_next;
            isect_reg        <= isect_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // Fill counts never pass the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CNT_W'(STORE_DEPTH) && count_b_reg <= CNT_W'(STORE_DEPTH))
        else $error("store count above depth");

    // The walk never has more left to pop than the store holds
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> rem_a_reg <= count_a_reg && rem_b_reg <= count_b_reg)
        else $error("walk remainder above store count");

    // Status and empty results always close their command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.item_present |-> result.last)
        else $error("element-free result without last");

    // Store counts stay put while a walk is running
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |=> $stable(count_a_reg) && $stable(count_b_reg))
        else $error("store count changed during walk");
`endif

endmodule
